[hw/rtl/nrmc_pkg.sv]
// Shared constants, types and character helpers for the RMC sentence checker.
package nrmc_pkg;

    // Longest sentence in characters, default for the top-level parameter.
    localparam int MAX_LEN_DEFAULT = 128;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MINSEC_W = 7;
    localparam int OUT_W    = 24;

    // Hour offset after reset.
    localparam logic [HOUR_W-1:0] HOUR_OFFSET_RESET = 5'd8;

    // Sentence layout: header, then six time digits, then the status search.
    localparam int HEADER_LEN     = 7;
    localparam int TIME_FIRST_POS = 7;
    localparam int TIME_DIGITS    = 6;
    localparam int STATUS_MIN_POS = 13;

    // Character codes.
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_ACTIVE = 8'h41;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    // Verdict for the current input item, handed from the sentence tracker to the top.
    typedef struct packed {
        logic                ends_sentence;
        logic                accepted;
        logic [MINSEC_W-1:0] hour_raw;
        logic [MINSEC_W-1:0] minute;
        logic [MINSEC_W-1:0] second;
    } nrmc_verdict_t;

    // Expected header character at positions 0 to 6: "$GPRMC,".
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'h24;
                3'd1:    c = 8'h47;
                3'd2:    c = 8'h50;
                3'd3:    c = 8'h52;
                3'd4:    c = 8'h4D;
                3'd5:    c = 8'h43;
                default: c = 8'h2C;
            endcase
            return c;
        end
    endfunction

    // Space, tab, CR and LF end a sentence.
    function automatic logic is_terminator(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Uppercase hex digits only.
    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (is_digit(c))
                v = c - 8'h30;
            else
                v = c - 8'h37;
            return v[3:0];
        end
    endfunction

    // Two decimal digits to a binary value, 0 to 99.
    function automatic logic [MINSEC_W-1:0] two_digits(input logic [3:0] tens,
                                                      input logic [3:0] ones);
        logic [MINSEC_W-1:0] t;
        begin
            t = MINSEC_W'(tens);
            return (t << 3) + (t << 1) + MINSEC_W'(ones);
        end
    endfunction

    // Reduce a value below 131 modulo 24 with three compare-and-subtract steps.
    function automatic logic [HOUR_W-1:0] mod24(input logic [7:0] sum);
        logic [7:0] v;
        begin
            v = sum;
            if (v >= 8'd96)
                v = v - 8'd96;
            if (v >= 8'd48)
                v = v - 8'd48;
            if (v >= 8'd24)
                v = v - 8'd24;
            return v[HOUR_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/nrmc_sentence_track.sv]
// Per-sentence state: header, time digits, status letter and checksum tracking.
module nrmc_sentence_track
    import nrmc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    output nrmc_verdict_t verdict
);

    localparam int POS_W = $clog2(MAX_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 1);

    logic [POS_W-1:0] char_position_reg, char_position_next;
    logic             header_match_reg, header_match_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic             star_seen_reg, star_seen_next;
    logic [7:0]       received_sum_reg, received_sum_next;
    logic [1:0]       received_digits_reg, received_digits_next;
    logic             format_fault_reg, format_fault_next;
    logic             status_found_reg, status_found_next;
    logic             status_active_reg, status_active_next;
    logic [3:0]       time_digits_reg [TIME_DIGITS];
    logic [3:0]       time_digits_next [TIME_DIGITS];
    logic             term;

    assign term = is_terminator(data_byte);

    // Verdict for a terminator, from the state before it.
    always_comb
    begin
        verdict.ends_sentence = term && (char_position_reg != '0);
        verdict.accepted = header_match_reg
            && (char_position_reg > POS_W'(STATUS_MIN_POS))
            && status_found_reg && status_active_reg && star_seen_reg
            && (received_digits_reg == 2'd2)
            && (received_sum_reg == running_xor_reg)
            && !format_fault_reg;
        verdict.hour_raw = two_digits(time_digits_reg[0], time_digits_reg[1]);
        verdict.minute   = two_digits(time_digits_reg[2], time_digits_reg[3]);
        verdict.second   = two_digits(time_digits_reg[4], time_digits_reg[5]);
    end

    // Next state for one character, or a clear at a terminator.
    always_comb
    begin
        char_position_next   = char_position_reg;
        header_match_next    = header_match_reg;
        running_xor_next     = running_xor_reg;
        star_seen_next       = star_seen_reg;
        received_sum_next    = received_sum_reg;
        received_digits_next = received_digits_reg;
        format_fault_next    = format_fault_reg;
        status_found_next    = status_found_reg;
        status_active_next   = status_active_reg;
        for (int i = 0; i < TIME_DIGITS; i++)
        begin
            time_digits_next[i] = time_digits_reg[i];
        end

        if (term)
        begin
            char_position_next   = '0;
            header_match_next    = 1'b1;
            running_xor_next     = '0;
            star_seen_next       = 1'b0;
            received_sum_next    = '0;
            received_digits_next = '0;
            format_fault_next    = 1'b0;
            status_found_next    = 1'b0;
            status_active_next   = 1'b0;
            for (int i = 0; i < TIME_DIGITS; i++)
            begin
                time_digits_next[i] = '0;
            end
        end
        else if (char_position_reg >= POS_LAST)
        begin
            // Sentence too long: reject and stop counting.
            format_fault_next = 1'b1;
        end
        else
        begin
            if ((char_position_reg < POS_W'(HEADER_LEN))
                && (data_byte != header_char(char_position_reg[2:0])))
                header_match_next = 1'b0;

            for (int i = 0; i < TIME_DIGITS; i++)
            begin
                if (char_position_reg == POS_W'(TIME_FIRST_POS + i))
                begin
                    if (is_digit(data_byte))
                        time_digits_next[i] = data_byte[3:0];
                    else
                        format_fault_next = 1'b1;
                end
            end

            if ((char_position_reg >= POS_W'(STATUS_MIN_POS)) && !status_found_reg
                && is_letter(data_byte))
            begin
                status_found_next  = 1'b1;
                status_active_next = (data_byte == CHAR_ACTIVE);
            end

            // Checksum covers everything after the first character up to the star.
            if (char_position_reg != '0)
            begin
                if (star_seen_reg)
                begin
                    if (!is_hex(data_byte) || (received_digits_reg >= 2'd2))
                        format_fault_next = 1'b1;
                    else
                    begin
                        received_sum_next    = {received_sum_reg[3:0], hex_value(data_byte)};
                        received_digits_next = received_digits_reg + 2'd1;
                    end
                end
                else if (data_byte == CHAR_STAR)
                    star_seen_next = 1'b1;
                else
                    running_xor_next = running_xor_reg ^ data_byte;
            end

            char_position_next = char_position_reg + POS_W'(1);
        end
    end

    // State registers, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg   <= '0;
            header_match_reg    <= 1'b1;
            running_xor_reg     <= '0;
            star_seen_reg       <= 1'b0;
            received_sum_reg    <= '0;
            received_digits_reg <= '0;
            format_fault_reg    <= 1'b0;
            status_found_reg    <= 1'b0;
            status_active_reg   <= 1'b0;
            for (int i = 0; i < TIME_DIGITS; i++)
            begin
                time_digits_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            char_position_reg   <= char_position_next;
            header_match_reg    <= header_match_next;
            running_xor_reg     <= running_xor_next;
            star_seen_reg       <= star_seen_next;
            received_sum_reg    <= received_sum_next;
            received_digits_reg <= received_digits_next;
            format_fault_reg    <= format_fault_next;
            status_found_reg    <= status_found_next;
            status_active_reg   <= status_active_next;
            for (int i = 0; i < TIME_DIGITS; i++)
            begin
                time_digits_reg[i] <= time_digits_next[i];
            end
        end
    end

    // The position saturates one below the sentence limit.
    assert property (@(posedge clk) disable iff (!rst_n) char_position_reg <= POS_LAST)
        else $error("character position ran past the sentence limit");

    // No more than two checksum digits are ever stored.
    assert property (@(posedge clk) disable iff (!rst_n) received_digits_reg <= 2'd2)
        else $error("checksum digit count above two");

    // A terminator leaves the sentence state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && term |=> char_position_reg == '0 && !star_seen_reg && !format_fault_reg)
        else $error("sentence state not cleared after a terminator");

endmodule

[hw/rtl/nmea_rmc_sentence_checker.sv]
// Top level of the RMC sentence checker: stream ports, saved time and result register.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] data_byte
//  m_axis   | out       | tdata[0] sentence_accepted, [1] have_time, [6:2] local_hour,
//           |           |   [13:7] minute, [20:14] second, [23:21] zero
//  cfg      | in        | cfg_wr_data[4:0] hour_offset, written when cfg_wr_en is high
//
// One item per cycle while the output is not stalled: an item waits in the input register, and
// when it moves on, its result (if it ends a non-empty sentence) lands in the output register.
// The per-sentence state update is the single recurrence.
// Reset clears the valid flags and the sentence and saved-time state; the hour offset returns to 8.
// While a result waits in the output register, one more item is held in the input register.
module nmea_rmc_sentence_checker
    import nrmc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [0] sentence_accepted, [1] have_time,
                                              // [6:2] local_hour, [13:7] minute,
                                              // [20:14] second, [23:21] zero
    input  logic              cfg_wr_en,
    input  logic [HOUR_W-1:0] cfg_wr_data     // [4:0] hour_offset
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                advance;
    logic                step;
    nrmc_verdict_t       verdict;

    logic [HOUR_W-1:0]   hour_offset_reg;
    logic                saved_valid_reg, saved_valid_next;
    logic [HOUR_W-1:0]   saved_hour_reg, saved_hour_next;
    logic [MINSEC_W-1:0] saved_minute_reg, saved_minute_next;
    logic [MINSEC_W-1:0] saved_second_reg, saved_second_next;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // The pipe moves whenever the output register is free or being emptied.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hour_offset_reg <= HOUR_OFFSET_RESET;
        else if (cfg_wr_en)
            hour_offset_reg <= cfg_wr_data;
    end

    nrmc_sentence_track #(
        .MAX_LEN (MAX_LEN)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .verdict   (verdict)
    );

    // An accepted sentence replaces the saved time before the result is formed.
    always_comb
    begin
        saved_valid_next  = saved_valid_reg;
        saved_hour_next   = saved_hour_reg;
        saved_minute_next = saved_minute_reg;
        saved_second_next = saved_second_reg;
        if (verdict.ends_sentence && verdict.accepted)
        begin
            saved_valid_next  = 1'b1;
            saved_hour_next   = mod24(8'(verdict.hour_raw) + 8'(hour_offset_reg));
            saved_minute_next = verdict.minute;
            saved_second_next = verdict.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_valid_reg  <= 1'b0;
            saved_hour_reg   <= '0;
            saved_minute_reg <= '0;
            saved_second_reg <= '0;
        end
        else if (step)
        begin
            saved_valid_reg  <= saved_valid_next;
            saved_hour_reg   <= saved_hour_next;
            saved_minute_reg <= saved_minute_next;
            saved_second_reg <= saved_second_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step && verdict.ends_sentence;
    end

    always_ff @(posedge clk)
    begin
        if (step && verdict.ends_sentence)
            out_data_reg <= {3'b000, saved_second_next, saved_minute_next, saved_hour_next,
                             saved_valid_next, verdict.accepted};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The hour in a result is always reduced below 24.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:2] < 5'd24)
        else $error("local hour not reduced modulo 24");

    // An accepted sentence always reports a held time.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("accepted sentence without a held time");

    // Once a time is held it stays held.
    assert property (@(posedge clk) disable iff (!rst_n)
        saved_valid_reg |=> saved_valid_reg)
        else $error("held time was dropped");

    // A buffered item waits while the output is stalled and is not lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("buffered item lost during an output stall");

endmodule
